@@ design/http_request_header_tokenizer_defines.svh @@
// Assertion macros used by the HTTP request header tokenizer top level.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH

// Checked property, disabled while reset is asserted.
`define HRHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked property, evaluated during reset as well.
`define HRHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/hrht_pkg.sv @@
// Types and constants of the HTTP request header tokenizer.
`timescale 1ns / 1ps
package hrht_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [7:0] {
    PH_METHOD   = 8'b0000_0001,
    PH_ENDPOINT = 8'b0000_0010,
    PH_VERSION  = 8'b0000_0100,
    PH_KEY      = 8'b0000_1000,
    PH_SKIP     = 8'b0001_0000,
    PH_VALUE    = 8'b0010_0000,
    PH_ROWDONE  = 8'b0100_0000,
    PH_DISCARD  = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    TAG_METHOD   = 3'd0,
    TAG_ENDPOINT = 3'd1,
    TAG_VERSION  = 3'd2,
    TAG_KEY      = 3'd3,
    TAG_VALUE    = 3'd4,
    TAG_DELIM    = 3'd5,
    TAG_DROP     = 3'd6
  } tag_e;

  typedef struct packed {
    phase_e phase;
    logic   row_empty;
    logic   skip_lf;
  } parse_state_t;

endpackage

@@ design/hrht_in_if.sv @@
// Input channel carrying one request byte per transfer.
`timescale 1ns / 1ps
interface hrht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

@@ design/hrht_out_if.sv @@
// Output channel carrying one tagged byte per transfer.
`timescale 1ns / 1ps
interface hrht_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [2:0] field_tag;
  logic [4:0] header_index;
  logic       request_end;

  modport source (output valid, byte_out, field_tag, header_index, request_end, input ready);
  modport sink (input valid, byte_out, field_tag, header_index, request_end, output ready);
endinterface

@@ design/http_request_header_tokenizer.sv @@
// Top level of the HTTP request header tokenizer.
// The block takes a received HTTP request one byte per transfer on req_i and
// returns each byte on tok_o tagged as method, endpoint, version, header key,
// header value, delimiter or dropped, with the header row number for key and
// value bytes. One byte is held back as lookahead, so the result for a byte
// is produced when the following byte is accepted. The byte marked last is
// the terminator: it produces no result of its own, the held byte goes out
// with request_end set, and the parser returns to its reset state so that a
// new request may follow at once.
// A byte is accepted in every cycle while tok_o is empty or being drained,
// so the sustained rate is one byte per cycle. A result appears on tok_o in the
// cycle after the transfer of the byte that follows it; it passes through the
// single result register. When the receiver stalls, the result waits in
// its register and req_i.ready drops until it is taken.
// Reset clears the held byte, the parser state and the result valid flag; no
// clearing pass is needed.
`timescale 1ns / 1ps
`include "http_request_header_tokenizer_defines.svh"
module http_request_header_tokenizer #(
  parameter int ROW_LIMIT    = 32,
  parameter int HEADER_LIMIT = 31
) (
  input logic      clk_i,
  input logic      rst_ni,
  hrht_in_if.sink  req_i,
  hrht_out_if.source tok_o
);

  localparam int CntW = $clog2(ROW_LIMIT + 1);

  localparam hrht_pkg::parse_state_t StateRst = '{
    phase:     hrht_pkg::PH_METHOD,
    row_empty: 1'b1,
    skip_lf:   1'b0
  };

  logic                   accept;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             held_q, held_d;
  logic                   held_valid_q, held_valid_d;
  hrht_pkg::parse_state_t st_q, st_d, st_nxt;
  logic [CntW-1:0]        cnt_q, cnt_d, cnt_nxt;
  hrht_pkg::tag_e         tag;
  logic [4:0]             hidx;
  logic [7:0]             byte_q;
  logic [2:0]             tag_q;
  logic [4:0]             hidx_q;
  logic                   end_q;

  hrht_classify #(
    .ROW_LIMIT    (ROW_LIMIT),
    .HEADER_LIMIT (HEADER_LIMIT)
  ) u_classify (
    .cur_i  (st_q),
    .cnt_i  (cnt_q),
    .held_i (held_q),
    .data_i (req_i.data_byte),
    .last_i (req_i.last_byte),
    .nxt_o  (st_nxt),
    .cnt_o  (cnt_nxt),
    .tag_o  (tag),
    .hidx_o (hidx)
  );

  assign req_i.ready = !out_valid_q || tok_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    st_d         = st_q;
    cnt_d        = cnt_q;
    if (accept) begin
      out_valid_d = held_valid_q;
      if (req_i.last_byte) begin
        held_d       = 8'd0;
        held_valid_d = 1'b0;
        st_d         = StateRst;
        cnt_d        = '0;
      end else begin
        held_d       = req_i.data_byte;
        held_valid_d = 1'b1;
        if (held_valid_q) begin
          st_d  = st_nxt;
          cnt_d = cnt_nxt;
        end
      end
    end else if (tok_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      held_q       <= 8'd0;
      held_valid_q <= 1'b0;
      st_q         <= StateRst;
      cnt_q        <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      st_q         <= st_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_valid_q) begin
      byte_q <= held_q;
      tag_q  <= tag;
      hidx_q <= hidx;
      end_q  <= req_i.last_byte;
    end
  end

  assign tok_o.valid        = out_valid_q;
  assign tok_o.byte_out     = byte_q;
  assign tok_o.field_tag    = tag_q;
  assign tok_o.header_index = hidx_q;
  assign tok_o.request_end  = end_q;

  `HRHT_ASSERT(a_no_result_without_held, accept && !held_valid_q |=> !out_valid_q, "result without held byte")
  `HRHT_ASSERT(a_last_resets, accept && req_i.last_byte |=> !held_valid_q && st_q.phase == hrht_pkg::PH_METHOD && cnt_q == '0, "terminator did not reset parser")
  `HRHT_ASSERT(a_hidx_only_fields, out_valid_q && tag_q != hrht_pkg::TAG_KEY && tag_q != hrht_pkg::TAG_VALUE |-> hidx_q == 5'd0, "header index on non-header byte")
  `HRHT_ASSERT_ALWAYS(a_skip_lf_held, st_q.skip_lf |-> held_valid_q && held_q == hrht_pkg::CH_LF, "pending line feed not held")

endmodule

@@ design/hrht_classify.sv @@
// Combinational classifier of the held byte and next parser state.
`timescale 1ns / 1ps
module hrht_classify #(
  parameter int ROW_LIMIT    = 32,
  parameter int HEADER_LIMIT = 31,
  localparam int CntW        = $clog2(ROW_LIMIT + 1)
) (
  input  hrht_pkg::parse_state_t cur_i,
  input  logic [CntW-1:0]        cnt_i,
  input  logic [7:0]             held_i,
  input  logic [7:0]             data_i,
  input  logic                   last_i,
  output hrht_pkg::parse_state_t nxt_o,
  output logic [CntW-1:0]        cnt_o,
  output hrht_pkg::tag_e         tag_o,
  output logic [4:0]             hidx_o
);

  localparam int HidxW = (CntW > 5) ? CntW : 5;

  logic            split;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] cnt_m1;
  logic            over_limit;
  logic [HidxW-1:0] hidx_ext;

  assign split   = (held_i == hrht_pkg::CH_CR) && !last_i && (data_i == hrht_pkg::CH_LF);
  assign cnt_inc = cnt_i + CntW'(1);
  assign over_limit = (32'(cnt_inc) >= 32'(ROW_LIMIT)) ||
                      (32'(cnt_inc) >= 32'(HEADER_LIMIT) + 32'd1);

  always_comb begin
    nxt_o = cur_i;
    cnt_o = cnt_i;
    tag_o = hrht_pkg::TAG_DROP;
    if (cur_i.skip_lf) begin
      nxt_o.skip_lf = 1'b0;
      tag_o = hrht_pkg::TAG_DELIM;
    end else if (cur_i.phase == hrht_pkg::PH_DISCARD) begin
      tag_o = hrht_pkg::TAG_DROP;
    end else if (split) begin
      nxt_o.skip_lf = 1'b1;
      nxt_o.row_empty = 1'b1;
      tag_o = hrht_pkg::TAG_DELIM;
      if (cur_i.row_empty && (cnt_i != '0)) begin
        nxt_o.phase = hrht_pkg::PH_DISCARD;
      end else begin
        cnt_o = cnt_inc;
        nxt_o.phase = over_limit ? hrht_pkg::PH_DISCARD : hrht_pkg::PH_KEY;
      end
    end else begin
      nxt_o.row_empty = 1'b0;
      case (cur_i.phase)
        hrht_pkg::PH_METHOD: begin
          if (held_i == hrht_pkg::CH_SPACE) begin
            nxt_o.phase = hrht_pkg::PH_ENDPOINT;
            tag_o = hrht_pkg::TAG_DELIM;
          end else begin
            tag_o = hrht_pkg::TAG_METHOD;
          end
        end
        hrht_pkg::PH_ENDPOINT: begin
          if (held_i == hrht_pkg::CH_SPACE) begin
            nxt_o.phase = hrht_pkg::PH_VERSION;
            tag_o = hrht_pkg::TAG_DELIM;
          end else begin
            tag_o = hrht_pkg::TAG_ENDPOINT;
          end
        end
        hrht_pkg::PH_VERSION: begin
          tag_o = hrht_pkg::TAG_VERSION;
        end
        hrht_pkg::PH_KEY: begin
          if (held_i == hrht_pkg::CH_COLON) begin
            nxt_o.phase = hrht_pkg::PH_SKIP;
            tag_o = hrht_pkg::TAG_DELIM;
          end else begin
            tag_o = hrht_pkg::TAG_KEY;
          end
        end
        hrht_pkg::PH_SKIP: begin
          if (held_i == hrht_pkg::CH_SPACE) begin
            tag_o = hrht_pkg::TAG_DELIM;
          end else if (held_i == hrht_pkg::CH_CR || held_i == hrht_pkg::CH_LF) begin
            nxt_o.phase = hrht_pkg::PH_ROWDONE;
            tag_o = hrht_pkg::TAG_DELIM;
          end else begin
            nxt_o.phase = hrht_pkg::PH_VALUE;
            tag_o = hrht_pkg::TAG_VALUE;
          end
        end
        hrht_pkg::PH_VALUE: begin
          if (held_i == hrht_pkg::CH_CR || held_i == hrht_pkg::CH_LF) begin
            nxt_o.phase = hrht_pkg::PH_ROWDONE;
            tag_o = hrht_pkg::TAG_DELIM;
          end else begin
            tag_o = hrht_pkg::TAG_VALUE;
          end
        end
        default: begin
          tag_o = hrht_pkg::TAG_DROP;
        end
      endcase
    end
  end

  // Header rows are numbered from zero; the request line has no number.
  assign cnt_m1   = cnt_o - CntW'(1);
  assign hidx_ext = HidxW'(cnt_m1);

  always_comb begin
    hidx_o = 5'd0;
    if ((tag_o == hrht_pkg::TAG_KEY || tag_o == hrht_pkg::TAG_VALUE) && (cnt_o != '0)) begin
      hidx_o = hidx_ext[4:0];
    end
  end

endmodule

@@ dv/http_request_header_tokenizer_tb.sv @@
// Self-checking testbench that streams random HTTP requests through the tokenizer.
`timescale 1ns / 1ps
module http_request_header_tokenizer_tb;

  localparam int ROW_LIMIT    = 32;
  localparam int HEADER_LIMIT = 31;
  localparam int MAX_WAIT     = 18;
  localparam int TARGET_BYTES = 1050;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0]       data;
    hrht_pkg::tag_e   tag;
    logic [4:0]       hidx;
    logic             req_end;
  } token_t;

  class token_scoreboard;
    hrht_pkg::phase_e phase;
    logic [7:0]  held_byte;
    bit          held_valid;
    int unsigned row_num;
    bit          row_empty;
    bit          skip_lf;
    token_t      pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      reset_parser();
      mismatches = 0;
      checked = 0;
    endfunction

    function void reset_parser();
      phase = hrht_pkg::PH_METHOD;
      held_byte = '0;
      held_valid = 1'b0;
      row_num = 0;
      row_empty = 1'b1;
      skip_lf = 1'b0;
    endfunction

    function hrht_pkg::tag_e classify(logic [7:0] b, bit split);
      if (skip_lf) begin
        skip_lf = 1'b0;
        return hrht_pkg::TAG_DELIM;
      end
      if (phase == hrht_pkg::PH_DISCARD) return hrht_pkg::TAG_DROP;
      if (split) begin
        skip_lf = 1'b1;
        if (row_empty && row_num >= 1) begin
          phase = hrht_pkg::PH_DISCARD;
        end else begin
          row_num++;
          if (row_num >= ROW_LIMIT || row_num - 1 >= HEADER_LIMIT) begin
            phase = hrht_pkg::PH_DISCARD;
          end else begin
            phase = hrht_pkg::PH_KEY;
          end
        end
        row_empty = 1'b1;
        return hrht_pkg::TAG_DELIM;
      end
      row_empty = 1'b0;
      case (phase)
        hrht_pkg::PH_METHOD: begin
          if (b == hrht_pkg::CH_SPACE) begin
            phase = hrht_pkg::PH_ENDPOINT;
            return hrht_pkg::TAG_DELIM;
          end
          return hrht_pkg::TAG_METHOD;
        end
        hrht_pkg::PH_ENDPOINT: begin
          if (b == hrht_pkg::CH_SPACE) begin
            phase = hrht_pkg::PH_VERSION;
            return hrht_pkg::TAG_DELIM;
          end
          return hrht_pkg::TAG_ENDPOINT;
        end
        hrht_pkg::PH_VERSION: return hrht_pkg::TAG_VERSION;
        hrht_pkg::PH_KEY: begin
          if (b == hrht_pkg::CH_COLON) begin
            phase = hrht_pkg::PH_SKIP;
            return hrht_pkg::TAG_DELIM;
          end
          return hrht_pkg::TAG_KEY;
        end
        hrht_pkg::PH_SKIP: begin
          if (b == hrht_pkg::CH_SPACE) return hrht_pkg::TAG_DELIM;
          if (b == hrht_pkg::CH_CR || b == hrht_pkg::CH_LF) begin
            phase = hrht_pkg::PH_ROWDONE;
            return hrht_pkg::TAG_DELIM;
          end
          phase = hrht_pkg::PH_VALUE;
          return hrht_pkg::TAG_VALUE;
        end
        hrht_pkg::PH_VALUE: begin
          if (b == hrht_pkg::CH_CR || b == hrht_pkg::CH_LF) begin
            phase = hrht_pkg::PH_ROWDONE;
            return hrht_pkg::TAG_DELIM;
          end
          return hrht_pkg::TAG_VALUE;
        end
        default: return hrht_pkg::TAG_DROP;
      endcase
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      token_t t;
      bit     split;
      if (held_valid) begin
        split = (held_byte == hrht_pkg::CH_CR) && !last && (data == hrht_pkg::CH_LF);
        t.tag = classify(held_byte, split);
        t.data = held_byte;
        t.hidx = ((t.tag == hrht_pkg::TAG_KEY || t.tag == hrht_pkg::TAG_VALUE) &&
                  row_num >= 1) ? 5'(row_num - 1) : 5'd0;
        t.req_end = last;
        pending.push_back(t);
      end
      if (last) begin
        reset_parser();
      end else begin
        held_byte = data;
        held_valid = 1'b1;
      end
    endfunction

    function void check_token(logic [7:0] data, logic [2:0] tag, logic [4:0] hidx,
                              logic req_end);
      token_t want;
      if (pending.size() == 0) begin
        $error("Unexpected tagged byte %02h with tag %0d", data, tag);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (data !== want.data) begin
        $error("byte_out: expected %02h, got %02h", want.data, data);
        mismatches++;
      end
      if (tag !== want.tag) begin
        $error("field_tag: expected %0d, got %0d", want.tag, tag);
        mismatches++;
      end
      if (hidx !== want.hidx) begin
        $error("header_index: expected %0d, got %0d", want.hidx, hidx);
        mismatches++;
      end
      if (req_end !== want.req_end) begin
        $error("request_end: expected %0d, got %0d", want.req_end, req_end);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hrht_in_if  req_if ();
  hrht_out_if tok_if ();

  http_request_header_tokenizer #(
    .ROW_LIMIT    (ROW_LIMIT),
    .HEADER_LIMIT (HEADER_LIMIT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .tok_o  (tok_if)
  );

  token_scoreboard sb = new();

  bit          sender_quiet;
  bit          receiver_quiet;
  bit          hold_requested;
  int unsigned bytes_sent;
  int unsigned requests_sent;
  int unsigned overlong_requests;
  logic [7:0]  req_bytes[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d tagged bytes outstanding.", sb.pending.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 4))
      0: return hrht_pkg::CH_CR;
      1: return hrht_pkg::CH_LF;
      2: return hrht_pkg::CH_COLON;
      3: return hrht_pkg::CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_text(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(lo, hi)) req_bytes.push_back(text_char());
  endtask

  task automatic add_crlf();
    req_bytes.push_back(hrht_pkg::CH_CR);
    req_bytes.push_back(hrht_pkg::CH_LF);
  endtask

  task automatic build_request(input int unsigned headers, input int unsigned noise_pct,
                               input int unsigned field_max);
    req_bytes.delete();
    add_text(1, 6);
    req_bytes.push_back(hrht_pkg::CH_SPACE);
    add_text(1, 10);
    req_bytes.push_back(hrht_pkg::CH_SPACE);
    repeat ($urandom_range(1, 8)) begin
      req_bytes.push_back(($urandom_range(0, 5) == 0) ? hrht_pkg::CH_SPACE : text_char());
    end
    add_crlf();
    repeat (headers) begin
      add_text(0, field_max);
      if ($urandom_range(0, 5) != 0) req_bytes.push_back(hrht_pkg::CH_COLON);
      repeat ($urandom_range(0, 2)) req_bytes.push_back(hrht_pkg::CH_SPACE);
      add_text(0, field_max);
      add_crlf();
    end
    add_crlf();
    add_text(0, 3);
    foreach (req_bytes[i]) begin
      if ($urandom_range(0, 99) < noise_pct) req_bytes[i] = special_byte();
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
    end
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.data_byte = data;
    req_if.last_byte = last;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_byte(data, last);
    bytes_sent++;
  endtask

  task automatic send_request();
    foreach (req_bytes[i]) send_byte(req_bytes[i], 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    requests_sent++;
  endtask

  task automatic wait_all_tokens();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    int unsigned taken;
    tok_if.ready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = receiver_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      repeat (stall) begin
        @(negedge clk_i);
        tok_if.ready = 1'b0;
      end
      @(negedge clk_i);
      tok_if.ready = 1'b1;
      do @(posedge clk_i); while (!tok_if.valid);
      sb.check_token(tok_if.byte_out, tok_if.field_tag, tok_if.header_index,
                     tok_if.request_end);
      taken++;
      if (taken % 50 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned kind;
    req_if.valid = 1'b0;
    req_if.data_byte = '0;
    req_if.last_byte = 1'b0;
    rst_ni = 1'b0;
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    hold_requested = 1'b0;
    bytes_sent = 0;
    requests_sent = 0;
    overlong_requests = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A terminator with nothing held produces no transfer.
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    // Extreme bytes, every field, an empty row that ends the request and trailing bytes.
    req_bytes = {8'hFF, hrht_pkg::CH_SPACE, 8'h00, hrht_pkg::CH_SPACE, 8'h76,
                 hrht_pkg::CH_CR, hrht_pkg::CH_LF,
                 8'h6B, hrht_pkg::CH_COLON, hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE, 8'h77,
                 hrht_pkg::CH_CR, hrht_pkg::CH_LF,
                 8'h6E, hrht_pkg::CH_CR, hrht_pkg::CH_LF, hrht_pkg::CH_CR, hrht_pkg::CH_LF,
                 8'h7A};
    send_request();
    // A CR right before the terminator is ordinary data.
    req_bytes = {8'h6D, hrht_pkg::CH_CR};
    send_request();

    while (bytes_sent < TARGET_BYTES) begin
      kind = $urandom_range(0, 99);
      sender_quiet = ($urandom_range(0, 3) == 0);
      if (requests_sent == 12) begin
        build_request(33, 0, 2);
        overlong_requests++;
      end else if (kind < 65) begin
        build_request($urandom_range(0, 5), 0, 8);
      end else if (kind < 80) begin
        build_request($urandom_range(0, 5), 5, 8);
      end else if (kind < 90) begin
        build_request($urandom_range(0, 3), 0, 6);
        kind = $urandom_range(0, req_bytes.size() - 1);
        while (req_bytes.size() > kind) void'(req_bytes.pop_back());
      end else begin
        req_bytes.delete();
        repeat ($urandom_range(0, 20)) req_bytes.push_back(special_byte());
      end
      if (requests_sent == 6) hold_requested = 1'b1;
      if (requests_sent == 25) wait_all_tokens();
      send_request();
    end

    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait_all_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d requests, %0d of them past the header limit.",
             bytes_sent, requests_sent, overlong_requests);
    $display("Checked %0d tagged bytes, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
